// ===== src/ctl_pkg.sv =====
// Package for the C-style token lexer: token and mode types, token kind codes,
// character constants and character class helpers.
// Depends on nothing; used by every module of the lexer.
`default_nettype none

package ctl_pkg;

  // Lexer mode between bytes.
  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_SLASH = 4'd1,
    M_LINE  = 4'd2,
    M_BLOCK = 4'd3,
    M_BSTAR = 4'd4,
    M_STR   = 4'd5,
    M_ESC   = 4'd6,
    M_IDENT = 4'd7,
    M_NUM   = 4'd8
  } lex_mode_t;

  localparam logic [4:0] K_END     = 5'd0;
  localparam logic [4:0] K_LPAREN  = 5'd1;
  localparam logic [4:0] K_RPAREN  = 5'd2;
  localparam logic [4:0] K_COLON   = 5'd3;
  localparam logic [4:0] K_SEMI    = 5'd4;
  localparam logic [4:0] K_STAR    = 5'd5;
  localparam logic [4:0] K_LBRACK  = 5'd6;
  localparam logic [4:0] K_RBRACK  = 5'd7;
  localparam logic [4:0] K_LBRACE  = 5'd8;
  localparam logic [4:0] K_RBRACE  = 5'd9;
  localparam logic [4:0] K_HASH    = 5'd10;
  localparam logic [4:0] K_COMMA   = 5'd11;
  localparam logic [4:0] K_STRING  = 5'd12;
  localparam logic [4:0] K_IDENT   = 5'd13;
  localparam logic [4:0] K_INT     = 5'd14;
  localparam logic [4:0] K_FLOAT   = 5'd15;
  localparam logic [4:0] K_UNKNOWN = 5'd16;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam int TOK_FIELD_BITS = 24;
  localparam logic [TOK_FIELD_BITS-1:0] TOK_FIELD_MAX = 24'hFFFFFF;

  // Result queue geometry.
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = 2;
  localparam int QLVL_BITS = 3;

  typedef struct packed {
    logic [4:0]                kind;
    logic [TOK_FIELD_BITS-1:0] start;
    logic [TOK_FIELD_BITS-1:0] length;
    logic                      last;
  } token_t;

  // Up to two tokens per byte, handed from the lexer core to the queue.
  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  typedef struct packed {
    logic                 space_ok;
    logic [QLVL_BITS-1:0] level;
  } q_stat_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

`default_nettype wire

// ===== src/ctl_lex_core.sv =====
// Lexer core: input byte register, mode state and the per-byte token step.
// Depends on ctl_pkg; feeds ctl_out_queue through a ctl_pkg::push_t.
`default_nettype none

module ctl_lex_core #(
  parameter int OFFSET_BITS = 24
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_byte_in,
  input  wire logic           space_ok,
  output ctl_pkg::push_t      push
);

  localparam int LW = (OFFSET_BITS > ctl_pkg::TOK_FIELD_BITS) ? OFFSET_BITS
                                                              : ctl_pkg::TOK_FIELD_BITS;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  logic                    in_vld_r;
  logic [7:0]              in_byte_r;
  ctl_pkg::lex_mode_t      mode_r, mode_nxt;
  logic                    dec_r, dec_nxt;
  logic [OFFSET_BITS-1:0]  pstart_r, pstart_nxt;
  logic [OFFSET_BITS-1:0]  off_r, off_nxt;
  logic                    fire;

  logic [OFFSET_BITS-1:0]  off_inc;
  logic [OFFSET_BITS-1:0]  diff;
  logic [LW-1:0]           diff_ext;
  logic [23:0]             open_len;
  logic [23:0]             pstart_tok;
  logic [23:0]             off_tok;
  logic                    relex;
  logic                    e0_v, e1_v;
  logic [4:0]              e0_kind, e1_kind;
  logic [23:0]             e0_start, e0_len;
  ctl_pkg::token_t         t0, t1;
  logic [7:0]              c;

  assign fire     = in_vld_r && space_ok;
  assign in_ready = !in_vld_r || space_ok;
  assign c        = in_byte_r;

  assign off_inc    = (off_r == OFF_MAX) ? off_r : off_r + 1'b1;
  assign diff       = (off_r >= pstart_r) ? off_r - pstart_r : '0;
  assign diff_ext   = LW'(diff);
  assign open_len   = (diff_ext > LW'(ctl_pkg::TOK_FIELD_MAX)) ? ctl_pkg::TOK_FIELD_MAX
                                                               : diff_ext[23:0];
  assign pstart_tok = LW'(pstart_r) >> 0 == '0 ? 24'd0 : 24'(LW'(pstart_r));
  assign off_tok    = 24'(LW'(off_r));

  always_comb begin
    mode_nxt   = mode_r;
    dec_nxt    = dec_r;
    pstart_nxt = pstart_r;
    relex      = 1'b0;
    e0_v       = 1'b0;
    e0_kind    = ctl_pkg::K_UNKNOWN;
    e0_start   = pstart_tok;
    e0_len     = open_len;
    e1_v       = 1'b0;
    e1_kind    = ctl_pkg::K_UNKNOWN;

    // First pass: close or extend whatever token or comment is open.
    case (mode_r)
      ctl_pkg::M_SLASH: begin
        if (c == ctl_pkg::CH_SLASH) begin
          mode_nxt = ctl_pkg::M_LINE;
        end else if (c == ctl_pkg::CH_STAR) begin
          mode_nxt = ctl_pkg::M_BLOCK;
        end else begin
          e0_v    = 1'b1;
          e0_kind = ctl_pkg::K_UNKNOWN;
          e0_len  = 24'd1;
          relex   = 1'b1;
        end
      end
      ctl_pkg::M_LINE: begin
        if (c == ctl_pkg::CH_LF || c == ctl_pkg::CH_CR) begin
          mode_nxt = ctl_pkg::M_IDLE;
        end else if (c == ctl_pkg::CH_NUL) begin
          relex = 1'b1;
        end
      end
      ctl_pkg::M_BLOCK, ctl_pkg::M_BSTAR: begin
        if (c == ctl_pkg::CH_NUL) begin
          relex = 1'b1;
        end else if (c == ctl_pkg::CH_STAR) begin
          mode_nxt = ctl_pkg::M_BSTAR;
        end else if (c == ctl_pkg::CH_SLASH && mode_r == ctl_pkg::M_BSTAR) begin
          mode_nxt = ctl_pkg::M_IDLE;
        end else begin
          mode_nxt = ctl_pkg::M_BLOCK;
        end
      end
      ctl_pkg::M_STR, ctl_pkg::M_ESC: begin
        if (c == ctl_pkg::CH_NUL) begin
          e0_v    = 1'b1;
          e0_kind = ctl_pkg::K_STRING;
          relex   = 1'b1;
        end else if (mode_r == ctl_pkg::M_ESC) begin
          mode_nxt = ctl_pkg::M_STR;
        end else if (c == ctl_pkg::CH_QUOTE) begin
          e0_v     = 1'b1;
          e0_kind  = ctl_pkg::K_STRING;
          mode_nxt = ctl_pkg::M_IDLE;
        end else if (c == ctl_pkg::CH_BSLASH) begin
          mode_nxt = ctl_pkg::M_ESC;
        end
      end
      ctl_pkg::M_IDENT: begin
        if (!(ctl_pkg::is_alpha(c) || ctl_pkg::is_digit(c) || c == ctl_pkg::CH_UNDER)) begin
          e0_v    = 1'b1;
          e0_kind = ctl_pkg::K_IDENT;
          relex   = 1'b1;
        end
      end
      ctl_pkg::M_NUM: begin
        if (c == ctl_pkg::CH_DOT && !dec_r) begin
          dec_nxt = 1'b1;
        end else if (!ctl_pkg::is_digit(c)) begin
          e0_v    = 1'b1;
          e0_kind = dec_r ? ctl_pkg::K_FLOAT : ctl_pkg::K_INT;
          relex   = 1'b1;
        end
      end
      default: begin
        relex = 1'b1;
      end
    endcase

    // Second pass: lex the byte on its own from the between-tokens mode.
    if (relex) begin
      mode_nxt = ctl_pkg::M_IDLE;
      case (c)
        ctl_pkg::CH_NUL:    begin e1_v = 1'b1; e1_kind = ctl_pkg::K_END;    end
        ctl_pkg::CH_LPAREN: begin e1_v = 1'b1; e1_kind = ctl_pkg::K_LPAREN; end
        ctl_pkg::CH_RPAREN: begin e1_v = 1'b1; e1_kind = ctl_pkg::K_RPAREN; end
        ctl_pkg::CH_COLON:  begin e1_v = 1'b1; e1_kind = ctl_pkg::K_COLON;  end
        ctl_pkg::CH_SEMI:   begin e1_v = 1'b1; e1_kind = ctl_pkg::K_SEMI;   end
        ctl_pkg::CH_STAR:   begin e1_v = 1'b1; e1_kind = ctl_pkg::K_STAR;   end
        ctl_pkg::CH_LBRACK: begin e1_v = 1'b1; e1_kind = ctl_pkg::K_LBRACK; end
        ctl_pkg::CH_RBRACK: begin e1_v = 1'b1; e1_kind = ctl_pkg::K_RBRACK; end
        ctl_pkg::CH_LBRACE: begin e1_v = 1'b1; e1_kind = ctl_pkg::K_LBRACE; end
        ctl_pkg::CH_RBRACE: begin e1_v = 1'b1; e1_kind = ctl_pkg::K_RBRACE; end
        ctl_pkg::CH_HASH:   begin e1_v = 1'b1; e1_kind = ctl_pkg::K_HASH;   end
        ctl_pkg::CH_COMMA:  begin e1_v = 1'b1; e1_kind = ctl_pkg::K_COMMA;  end
        ctl_pkg::CH_SLASH: begin
          mode_nxt   = ctl_pkg::M_SLASH;
          pstart_nxt = off_r;
        end
        ctl_pkg::CH_QUOTE: begin
          mode_nxt   = ctl_pkg::M_STR;
          pstart_nxt = off_inc;
        end
        default: begin
          if (ctl_pkg::is_space(c)) begin
            mode_nxt = ctl_pkg::M_IDLE;
          end else if (ctl_pkg::is_alpha(c)) begin
            mode_nxt   = ctl_pkg::M_IDENT;
            pstart_nxt = off_r;
          end else if (ctl_pkg::is_digit(c)) begin
            mode_nxt   = ctl_pkg::M_NUM;
            dec_nxt    = 1'b0;
            pstart_nxt = off_r;
          end else begin
            e1_v    = 1'b1;
            e1_kind = ctl_pkg::K_UNKNOWN;
          end
        end
      endcase
    end

    off_nxt = (c == ctl_pkg::CH_NUL) ? '0 : off_inc;
  end

  always_comb begin
    t0.kind   = e0_kind;
    t0.start  = e0_start;
    t0.length = e0_len;
    t0.last   = !e1_v;
    t1.kind   = e1_kind;
    t1.start  = off_tok;
    t1.length = 24'd1;
    t1.last   = 1'b1;
    push.cnt  = fire ? (2'(e0_v) + 2'(e1_v)) : 2'd0;
    push.tok0 = e0_v ? t0 : t1;
    push.tok1 = t1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ctl_pkg::M_IDLE;
      dec_r    <= 1'b0;
      pstart_r <= '0;
      off_r    <= '0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      dec_r    <= dec_nxt;
      pstart_r <= pstart_nxt;
      off_r    <= off_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/ctl_out_queue.sv =====
// Result queue: four token entries, up to two pushed and one popped a cycle.
// Depends on ctl_pkg for token_t, push_t and q_stat_t.
`default_nettype none

module ctl_out_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  ctl_pkg::push_t         push,
  output ctl_pkg::q_stat_t       stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ctl_pkg::token_t        out_tok
);

  ctl_pkg::token_t                 tok_q_r [ctl_pkg::QDEPTH];
  logic [ctl_pkg::QPTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [ctl_pkg::QLVL_BITS-1:0]   level_r, level_nxt;
  logic                            pop;
  logic [ctl_pkg::QLVL_BITS-1:0]   level_after_pop;

  assign out_valid       = level_r != '0;
  assign pop             = out_valid && out_ready;
  assign out_tok         = tok_q_r[rd_ptr_r];
  assign level_after_pop = level_r - ctl_pkg::QLVL_BITS'(pop);
  assign level_nxt       = level_after_pop + ctl_pkg::QLVL_BITS'(push.cnt);

  always_comb begin
    stat.space_ok = level_after_pop <= ctl_pkg::QLVL_BITS'(ctl_pkg::QDEPTH - 2);
    stat.level    = level_r;
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      tok_q_r[wr_ptr_r] <= push.tok0;
    end
    if (push.cnt == 2'd2) begin
      tok_q_r[wr_ptr_r + 1'b1] <= push.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + ctl_pkg::QPTR_BITS'(push.cnt);
      rd_ptr_r <= rd_ptr_r + ctl_pkg::QPTR_BITS'(pop);
      level_r  <= level_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/c_style_token_lexer_unit.sv =====
// C-style token lexer, top level: wires the lexer core to the result queue.
// Depends on ctl_pkg, ctl_lex_core and ctl_out_queue.
//
// Streaming lexer for C-like source text. Each input word is one source byte;
// byte zero marks the end of a stream, emits an end token and restarts the
// offset count at zero. Whitespace, double-slash line comments and slash-star
// block comments are skipped. Every result word carries a token kind, the byte
// offset of its first character (for strings, the byte after the opening
// quote), its length (saturating at 2^24-1) and last_of_run, set on the final
// token that one byte produced. Identifiers and numbers are closed by the
// byte after them, which is then lexed on its own, so one byte can yield two
// tokens; strings end at their closing quote. Rate: one byte is taken per
// cycle while the queue has room; the result port hands out one token per
// cycle while out_ready is high, so bytes that yield two tokens fill the
// queue when the stream runs without idle gaps. The input holds off while
// the queue, after this cycle's pop, has more than two tokens in it. The
// first token of a byte passes through the input byte register, where the
// whole token step is done, into the four-entry result queue once it has
// room, and the queue's single read port sets the output rate.
`default_nettype none

module c_style_token_lexer_unit #(
  parameter int OFFSET_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_token_kind,
  output logic [23:0]      out_token_start,
  output logic [23:0]      out_token_length,
  output logic             out_last_of_run
);

  ctl_pkg::push_t   push;
  ctl_pkg::q_stat_t stat;
  ctl_pkg::token_t  out_tok;

  // Lex one byte a cycle whenever the queue can take two more tokens.
  ctl_lex_core #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte_in (in_byte_in),
    .space_ok   (stat.space_ok),
    .push       (push)
  );

  // Hold tokens until the consumer takes them, one per cycle.
  ctl_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (out_tok)
  );

  assign out_token_kind   = out_tok.kind;
  assign out_token_start  = out_tok.start;
  assign out_token_length = out_tok.length;
  assign out_last_of_run  = out_tok.last;

`ifndef SYNTHESIS
  // Queue never holds more than its depth.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.level <= ctl_pkg::QLVL_BITS'(ctl_pkg::QDEPTH))
    else $error("result queue overflow");

  // Tokens are pushed only when room for two was checked.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> stat.space_ok)
    else $error("token pushed without queue room");

  // A pop with no push lowers the level by exactly one.
  a_pop_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && push.cnt == 2'd0) |=> (stat.level == $past(stat.level) - 1'b1))
    else $error("queue level mismatch after pop");
`endif

endmodule

`default_nettype wire
